>>> hdl/imuaxs_pkg.sv
// Shared types, widths, operation codes and register indexes for the IMU smoothing block.
`default_nettype none
package imuaxs_pkg;

  localparam int WINDOW_TAPS_DEF   = 8;
  localparam int CALIB_SAMPLES_DEF = 32;

  localparam int SAMPLE_W   = 16;
  localparam int TICK_W     = 24;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int AXES       = 3;

  localparam logic [SAMPLE_W-1:0] ONE_G             = 16'd16384;
  localparam logic [TICK_W-1:0]   STARTUP_DELAY_RST = 24'd1000;

  // Operation codes carried by the sample channel.
  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_GYRO  = 2'd0;
  localparam op_t OP_ACCEL = 2'd1;
  localparam op_t OP_CALIB = 2'd2;

  // Configuration register indexes.
  typedef logic [CFG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_STARTUP_DELAY = 3'd0;
  localparam reg_idx_t REG_GYRO_TRIM_X   = 3'd1;
  localparam reg_idx_t REG_GYRO_TRIM_Y   = 3'd2;
  localparam reg_idx_t REG_GYRO_TRIM_Z   = 3'd3;
  localparam reg_idx_t REG_ACCEL_TRIM_X  = 3'd4;
  localparam reg_idx_t REG_ACCEL_TRIM_Y  = 3'd5;
  localparam reg_idx_t REG_ACCEL_TRIM_Z  = 3'd6;

  // One three-axis value, x in element 0, y in 1, z in 2.
  typedef logic [AXES-1:0][SAMPLE_W-1:0] axes_t;

endpackage
`default_nettype wire

>>> hdl/imuaxs_in_if.sv
// Sample channel interface: operation, three axis readings and elapsed ticks.
`default_nettype none
interface imuaxs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [imuaxs_pkg::OP_W-1:0]          operation;
  logic signed [imuaxs_pkg::SAMPLE_W-1:0] sample_x;
  logic signed [imuaxs_pkg::SAMPLE_W-1:0] sample_y;
  logic signed [imuaxs_pkg::SAMPLE_W-1:0] sample_z;
  logic [imuaxs_pkg::TICK_W-1:0]        elapsed_ticks;

  modport source (output valid, operation, sample_x, sample_y, sample_z, elapsed_ticks,
                  input ready);
  modport sink (input valid, operation, sample_x, sample_y, sample_z, elapsed_ticks,
                output ready);
endinterface
`default_nettype wire

>>> hdl/imuaxs_out_if.sv
// Result channel interface: trimmed and filtered axis values plus status flags.
`default_nettype none
interface imuaxs_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [imuaxs_pkg::SAMPLE_W-1:0] out_x;
  logic signed [imuaxs_pkg::SAMPLE_W-1:0] out_y;
  logic signed [imuaxs_pkg::SAMPLE_W-1:0] out_z;
  logic signed [imuaxs_pkg::SAMPLE_W-1:0] filtered_x;
  logic signed [imuaxs_pkg::SAMPLE_W-1:0] filtered_y;
  logic signed [imuaxs_pkg::SAMPLE_W-1:0] filtered_z;
  logic                                   startup_hold;
  logic                                   calibration_done;

  modport source (output valid, out_x, out_y, out_z, filtered_x, filtered_y, filtered_z,
                  startup_hold, calibration_done, input ready);
  modport sink (input valid, out_x, out_y, out_z, filtered_x, filtered_y, filtered_z,
                startup_hold, calibration_done, output ready);
endinterface
`default_nettype wire

>>> hdl/imuaxs_cfg_if.sv
// Configuration write channel interface: register index and write data.
`default_nettype none
interface imuaxs_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [imuaxs_pkg::CFG_IDX_W-1:0]      index;
  logic [imuaxs_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/imuaxs_cell.sv
// One window tap: holds a three-axis sample and takes its neighbor's on a push.
`default_nettype none
module imuaxs_cell (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 shift,
  input  imuaxs_pkg::axes_t   d,
  output imuaxs_pkg::axes_t   q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule
`default_nettype wire

>>> hdl/imuaxs_window.sv
// Moving window: a chain of tap cells and a running per-axis sum.
`default_nettype none
module imuaxs_window #(
  parameter int WINDOW_TAPS = imuaxs_pkg::WINDOW_TAPS_DEF,
  parameter int SUM_W       = imuaxs_pkg::SAMPLE_W + $clog2(WINDOW_TAPS)
) (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     push,
  input  imuaxs_pkg::axes_t                       sample,
  output logic [imuaxs_pkg::AXES-1:0][SUM_W-1:0]  sum_next
);

  localparam int EXT_W = SUM_W - imuaxs_pkg::SAMPLE_W;

  imuaxs_pkg::axes_t                      tap [WINDOW_TAPS];
  logic [imuaxs_pkg::AXES-1:0][SUM_W-1:0] sum;

  for (genvar i = 0; i < WINDOW_TAPS; i++) begin : g_tap
    if (i == 0) begin : g_head
      imuaxs_cell u_cell (.clk(clk), .rst(rst), .shift(push), .d(sample), .q(tap[i]));
    end else begin : g_body
      imuaxs_cell u_cell (.clk(clk), .rst(rst), .shift(push), .d(tap[i-1]), .q(tap[i]));
    end
  end

  // The sample leaving the tail is swapped for the one entering the head.
  always_comb begin
    for (int a = 0; a < imuaxs_pkg::AXES; a++) begin
      sum_next[a] = sum[a]
                  + {{EXT_W{sample[a][imuaxs_pkg::SAMPLE_W-1]}}, sample[a]}
                  - {{EXT_W{tap[WINDOW_TAPS-1][a][imuaxs_pkg::SAMPLE_W-1]}},
                     tap[WINDOW_TAPS-1][a]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (push) begin
      sum <= sum_next;
    end
  end

endmodule
`default_nettype wire

>>> hdl/imu_axis_smoothing_offset_trim.sv
// Top level: three-axis IMU moving-average filter with gyro bias calibration and trims.
// A sample passes through the stage 1, stage 2 and output registers on its way to the
// result channel. Throughput: one sample per cycle while the result channel takes
// results; the window sum is kept as a running sum in each window, so no stage holds
// more than a few 16 to 21 bit adds.
// Reset (rst, synchronous): windows, sums, bias and calibration count clear; the
// startup delay returns to 1000 ticks and all trims to zero. No clearing pass.
`default_nettype none
module imu_axis_smoothing_offset_trim #(
  parameter int WINDOW_TAPS   = imuaxs_pkg::WINDOW_TAPS_DEF,
  parameter int CALIB_SAMPLES = imuaxs_pkg::CALIB_SAMPLES_DEF
) (
  input wire            clk,
  input wire            rst,
  imuaxs_in_if.sink     sample,
  imuaxs_cfg_if.sink    cfg,
  imuaxs_out_if.source  result
);

  localparam int SW     = imuaxs_pkg::SAMPLE_W;
  localparam int NAX    = imuaxs_pkg::AXES;
  // Window sum width and the arithmetic shift that turns it into the average.
  localparam int SUM_W  = SW + $clog2(WINDOW_TAPS);
  localparam int SHIFT  = $clog2(WINDOW_TAPS + 1) - 1;
  // Calibration accumulator width, its averaging shift and the sample counter.
  localparam int CSUM_W = SW + $clog2(CALIB_SAMPLES);
  localparam int CSHIFT = $clog2(CALIB_SAMPLES + 1) - 1;
  localparam int CNT_W  = $clog2(CALIB_SAMPLES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CALIB_SAMPLES - 1);

  // Configuration registers. The write port never stalls; an index past the
  // last register is taken and dropped.
  logic [imuaxs_pkg::TICK_W-1:0] startup_delay;
  imuaxs_pkg::axes_t             gyro_trim;
  imuaxs_pkg::axes_t             accel_trim;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      startup_delay <= imuaxs_pkg::STARTUP_DELAY_RST;
      gyro_trim     <= '0;
      accel_trim    <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        imuaxs_pkg::REG_STARTUP_DELAY: startup_delay <= cfg.data;
        imuaxs_pkg::REG_GYRO_TRIM_X:   gyro_trim[0]  <= cfg.data[SW-1:0];
        imuaxs_pkg::REG_GYRO_TRIM_Y:   gyro_trim[1]  <= cfg.data[SW-1:0];
        imuaxs_pkg::REG_GYRO_TRIM_Z:   gyro_trim[2]  <= cfg.data[SW-1:0];
        imuaxs_pkg::REG_ACCEL_TRIM_X:  accel_trim[0] <= cfg.data[SW-1:0];
        imuaxs_pkg::REG_ACCEL_TRIM_Y:  accel_trim[1] <= cfg.data[SW-1:0];
        imuaxs_pkg::REG_ACCEL_TRIM_Z:  accel_trim[2] <= cfg.data[SW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control. Each stage moves when the stage after it is empty or
  // moving, so a result waiting in the output register does not stop a sample
  // transfer while the earlier stages still have room.
  logic s1_valid, s2_valid, res_valid;
  logic adv1, adv2, adv3;
  logic accept;

  assign adv3         = !res_valid || result.ready;
  assign adv2         = !s2_valid || adv3;
  assign adv1         = !s1_valid || adv2;
  assign sample.ready = adv1;
  assign accept       = sample.valid && adv1;

  // Stage 1: the transfer pushes the sample into its sensor's window. Gyro and
  // calibration samples share the gyro window; an unused code touches neither.
  imuaxs_pkg::axes_t          smp;
  logic                       gyro_push, accel_push;
  logic [NAX-1:0][SUM_W-1:0]  gyro_sum_next, accel_sum_next;

  assign smp[0] = sample.sample_x;
  assign smp[1] = sample.sample_y;
  assign smp[2] = sample.sample_z;

  assign gyro_push  = accept && (sample.operation == imuaxs_pkg::OP_GYRO ||
                                 sample.operation == imuaxs_pkg::OP_CALIB);
  assign accel_push = accept && (sample.operation == imuaxs_pkg::OP_ACCEL);

  imuaxs_window #(.WINDOW_TAPS(WINDOW_TAPS), .SUM_W(SUM_W)) u_gyro_window (
    .clk(clk), .rst(rst), .push(gyro_push), .sample(smp), .sum_next(gyro_sum_next)
  );

  imuaxs_window #(.WINDOW_TAPS(WINDOW_TAPS), .SUM_W(SUM_W)) u_accel_window (
    .clk(clk), .rst(rst), .push(accel_push), .sample(smp), .sum_next(accel_sum_next)
  );

  imuaxs_pkg::op_t            s1_op;
  logic                       s1_hold;
  logic [NAX-1:0][SUM_W-1:0]  s1_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= sample.valid;
    end
  end

  // The hold flag is settled here; the user must keep the delay register stable while
  // samples are in flight, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= sample.operation;
      s1_hold <= sample.elapsed_ticks < startup_delay;
      s1_sum  <= (sample.operation == imuaxs_pkg::OP_ACCEL) ? accel_sum_next
                                                             : gyro_sum_next;
    end
  end

  // Stage 2: average, bias removal and calibration. The bias is updated in this
  // stage, so a gyro sample right behind the last calibration sample sees it.
  imuaxs_pkg::axes_t           avg, filt, gyro_bias, bias_next;
  logic signed [SUM_W-1:0]     avg_wide [NAX];
  logic [NAX-1:0][CSUM_W-1:0]  calib_sums, csum_next;
  logic signed [CSUM_W-1:0]    bias_wide [NAX];
  logic [CNT_W-1:0]            calib_count;
  logic                        calib_take, calib_latch;

  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      avg_wide[a]  = $signed(s1_sum[a]) >>> SHIFT;
      avg[a]       = avg_wide[a][SW-1:0];
      csum_next[a] = calib_sums[a] + {{(CSUM_W-SW){avg[a][SW-1]}}, avg[a]};
      bias_wide[a] = $signed(csum_next[a]) >>> CSHIFT;
      bias_next[a] = bias_wide[a][SW-1:0];
    end
    case (s1_op) inside
      imuaxs_pkg::OP_GYRO: begin
        for (int a = 0; a < NAX; a++) filt[a] = avg[a] - gyro_bias[a];
      end
      imuaxs_pkg::OP_ACCEL, imuaxs_pkg::OP_CALIB: filt = avg;
      default: filt = '0;
    endcase
  end

  assign calib_take  = adv2 && s1_valid && (s1_op == imuaxs_pkg::OP_CALIB);
  assign calib_latch = calib_take && (calib_count == CNT_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_bias   <= '0;
      calib_sums  <= '0;
      calib_count <= '0;
    end else if (calib_latch) begin
      gyro_bias   <= bias_next;
      calib_sums  <= '0;
      calib_count <= '0;
    end else if (calib_take) begin
      calib_sums  <= csum_next;
      calib_count <= calib_count + CNT_W'(1);
    end
  end

  imuaxs_pkg::op_t    s2_op;
  logic               s2_hold, s2_done;
  imuaxs_pkg::axes_t  s2_filt;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      s2_op   <= s1_op;
      s2_hold <= s1_hold;
      s2_done <= calib_latch;
      s2_filt <= filt;
    end
  end

  // Stage 3: user trims and the one-g offset on accel z once the startup delay
  // has passed; the output register then holds the result until it is taken.
  imuaxs_pkg::axes_t res;

  always_comb begin
    res = s2_filt;
    if (!s2_hold) begin
      case (s2_op)
        imuaxs_pkg::OP_GYRO: begin
          for (int a = 0; a < NAX; a++) res[a] = s2_filt[a] - gyro_trim[a];
        end
        imuaxs_pkg::OP_ACCEL: begin
          for (int a = 0; a < NAX; a++) res[a] = s2_filt[a] - accel_trim[a];
          res[2] = s2_filt[2] - accel_trim[2] + imuaxs_pkg::ONE_G;
        end
        default: res = s2_filt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv3) begin
      res_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && s2_valid) begin
      result.out_x            <= res[0];
      result.out_y            <= res[1];
      result.out_z            <= res[2];
      result.filtered_x       <= s2_filt[0];
      result.filtered_y       <= s2_filt[1];
      result.filtered_z       <= s2_filt[2];
      result.startup_hold     <= s2_hold;
      result.calibration_done <= s2_done;
    end
  end

  assign result.valid = res_valid;

  // Latching a bias must restart the calibration count.
  a_latch_clears_count: assert property (@(posedge clk) disable iff (rst)
    calib_latch |=> calib_count == '0)
    else $error("calibration count not cleared after bias latch");

  // Only a calibration sample may report a new bias.
  a_done_only_calib: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_done |-> s2_op == imuaxs_pkg::OP_CALIB)
    else $error("calibration_done set on a non-calibration sample");

  // An unused operation code yields a zero filtered value and no bias latch.
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_op != imuaxs_pkg::OP_GYRO && s2_op != imuaxs_pkg::OP_ACCEL &&
    s2_op != imuaxs_pkg::OP_CALIB |-> s2_filt == '0 && !s2_done)
    else $error("unused operation produced a nonzero result");

  // No more than one window moves for a single transfer.
  a_one_window: assert property (@(posedge clk) disable iff (rst)
    !(gyro_push && accel_push))
    else $error("both windows pushed by one transfer");

endmodule
`default_nettype wire
